// ===== hw/rtl/ipr_pkg.sv =====
// Package for the picture-transfer receiver: item codes, byte constants,
// result record type and command byte tables. No dependencies.
`timescale 1ns / 1ps

package ipr_pkg;

    // input item codes (tuser on the slave side)
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_ABORT = 2'd2;

    // result kinds (tuser on the master side)
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_IMAGE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // status codes
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_ABORTED = 2'd3;

    localparam logic [7:0] BYTE_SYNC    = 8'hAA;
    localparam logic [7:0] BYTE_ACK_ID  = 8'h0E;
    localparam logic [7:0] BYTE_GET_ID  = 8'h04;
    localparam logic [7:0] BYTE_PICTURE = 8'h02;
    localparam logic [7:0] BYTE_FINAL   = 8'hF0;

    localparam int          CMD_LEN          = 6;
    localparam int          MAX_RESULTS      = 7;
    localparam logic [8:0]  PKG_DATA_RESET   = 9'd506;
    localparam logic [9:0]  PKG_OVERHEAD     = 10'd6;
    localparam logic [9:0]  PKG_HEADER_BYTES = 10'd4;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_MATCH   = 2'd1,
        PH_SIZE    = 2'd2,
        PH_PACKAGE = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [1:0] status;
    } result_t;

    // get-picture command: AA 04 02 00 00 00
    function automatic logic [7:0] get_picture_byte(input logic [2:0] k);
        logic [7:0] b;
        b = 8'h00;
        unique case (k)
            3'd0: b = BYTE_SYNC;
            3'd1: b = BYTE_GET_ID;
            3'd2: b = BYTE_PICTURE;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // expected reply AA 0E 04 00 00 00; zero matches any byte
    function automatic logic [7:0] reply_byte(input logic [2:0] k);
        logic [7:0] b;
        b = 8'h00;
        unique case (k)
            3'd0: b = BYTE_SYNC;
            3'd1: b = BYTE_ACK_ID;
            3'd2: b = BYTE_GET_ID;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // package request / final acknowledge: AA 0E 00 00 lo hi
    function automatic logic [7:0] request_byte(input logic [2:0] k,
                                                input logic [7:0] lo,
                                                input logic [7:0] hi);
        logic [7:0] b;
        b = 8'h00;
        unique case (k)
            3'd0: b = BYTE_SYNC;
            3'd1: b = BYTE_ACK_ID;
            3'd4: b = lo;
            3'd5: b = hi;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/image_package_receiver.sv =====
// Picture-transfer receiver: input register, single-pass decode logic and a result
// shift register draining one result per cycle while m_axis_tready is high. Uses ipr_pkg.
`timescale 1ns / 1ps

// Each item passes the input register, then the result shift register. One item
// per cycle while each item causes at most one result and m_axis_tready is high;
// an item that causes N results (command bursts, up to 7) holds the result shift
// register until all N drain, one result per cycle while m_axis_tready is high.
// One item waits in the input register meanwhile. Reset (rst_n, async, active
// low) returns to idle, clears all counters and sets package_data_bytes to 506.
module image_package_receiver
    import ipr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] value, [9:8] status, [15:10] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,   // last
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata       // package_data_bytes
);

    // input register
    logic       in_valid_reg;
    logic [1:0] in_cmd_reg;
    logic [7:0] in_byte_reg;

    // result shift register
    result_t    res_reg [MAX_RESULTS];
    logic [2:0] res_cnt_reg;

    // transfer state
    logic [8:0]  pkg_data_reg;
    phase_t      phase_reg,     phase_next;
    logic [2:0]  idx_reg,       idx_next;
    logic [23:0] size_reg,      size_next;
    logic [23:0] remain_reg,    remain_next;
    logic [15:0] pkg_num_reg,   pkg_num_next;
    logic [9:0]  pkg_idx_reg,   pkg_idx_next;
    logic [9:0]  pkg_len_reg,   pkg_len_next;

    result_t    res_next [MAX_RESULTS];
    logic [2:0] res_cnt_next;

    logic        advance;
    logic        do_start_pkg;
    logic [23:0] start_remain;
    logic [15:0] start_num;
    logic [8:0]  per_pkg;
    logic [9:0]  start_data;
    logic [10:0] pkg_idx_inc;
    logic [3:0]  match_inc;

    assign advance = in_valid_reg
                   && ((res_cnt_reg == 3'd0) || ((res_cnt_reg == 3'd1) && m_axis_tready));
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = (res_cnt_reg != 3'd0);
    assign m_axis_tlast  = (res_cnt_reg == 3'd1);
    assign m_axis_tuser  = res_reg[0].kind;
    assign m_axis_tdata  = {6'd0, res_reg[0].status, res_reg[0].value};

    // package length for the package that starts now
    assign per_pkg    = (pkg_data_reg == 9'd0) ? 9'd1 : pkg_data_reg;
    assign start_data = (start_remain < {15'd0, per_pkg}) ? start_remain[9:0]
                                                          : {1'b0, per_pkg};
    assign pkg_idx_inc = {1'b0, pkg_idx_reg} + 11'd1;
    assign match_inc   = {1'b0, idx_reg} + 4'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        size_next    = size_reg;
        remain_next  = remain_reg;
        pkg_num_next = pkg_num_reg;
        pkg_idx_next = pkg_idx_reg;
        pkg_len_next = pkg_len_reg;
        do_start_pkg = 1'b0;
        start_remain = remain_reg;
        start_num    = pkg_num_reg;
        res_cnt_next = 3'd0;
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            res_next[k] = '{kind: KIND_TX, value: 8'h00, status: ST_NONE};
        end

        unique case (in_cmd_reg)
            CMD_START:
            begin
                for (int k = 0; k < CMD_LEN; k++)
                begin
                    res_next[k].value = get_picture_byte(3'(k));
                end
                res_cnt_next = 3'(CMD_LEN);
                phase_next   = PH_MATCH;
                idx_next     = 3'd0;
                pkg_num_next = 16'd0;
                pkg_idx_next = 10'd0;
            end
            CMD_BYTE:
            begin
                unique case (phase_reg)
                    PH_MATCH:
                    begin
                        // skip a mismatching byte, keep the match position
                        if (reply_byte(idx_reg) == 8'h00 || reply_byte(idx_reg) == in_byte_reg)
                        begin
                            if (match_inc >= 4'(CMD_LEN))
                            begin
                                phase_next = PH_SIZE;
                                idx_next   = 3'd0;
                            end
                            else
                            begin
                                idx_next = match_inc[2:0];
                            end
                        end
                    end
                    PH_SIZE:
                    begin
                        unique case (idx_reg)
                            3'd3:    size_next = {size_reg[23:8], in_byte_reg};
                            3'd4:    size_next = {size_reg[23:16], in_byte_reg, size_reg[7:0]};
                            3'd5:    size_next = {in_byte_reg, size_reg[15:0]};
                            default: size_next = size_reg;
                        endcase
                        if (match_inc >= 4'(CMD_LEN))
                        begin
                            idx_next     = 3'd0;
                            remain_next  = size_next;
                            pkg_num_next = 16'd0;
                            if (size_next == 24'd0)
                            begin
                                res_next[0]  = '{kind: KIND_STATUS, value: 8'h00,
                                                 status: ST_EMPTY};
                                res_cnt_next = 3'd1;
                                phase_next   = PH_IDLE;
                            end
                            else
                            begin
                                do_start_pkg = 1'b1;
                                start_remain = size_next;
                                start_num    = 16'd0;
                            end
                        end
                        else
                        begin
                            idx_next = match_inc[2:0];
                        end
                    end
                    PH_PACKAGE:
                    begin
                        // drop header and trailer bytes
                        if (pkg_idx_reg >= PKG_HEADER_BYTES
                            && ({1'b0, pkg_idx_reg} + 11'd2) < {1'b0, pkg_len_reg}
                            && remain_reg != 24'd0)
                        begin
                            res_next[0]  = '{kind: KIND_IMAGE, value: in_byte_reg,
                                             status: ST_NONE};
                            res_cnt_next = 3'd1;
                            remain_next  = remain_reg - 24'd1;
                        end
                        pkg_idx_next = pkg_idx_inc[9:0];
                        if (pkg_idx_inc >= {1'b0, pkg_len_reg})
                        begin
                            pkg_num_next = pkg_num_reg + 16'd1;
                            if (remain_next == 24'd0)
                            begin
                                for (int k = 0; k < CMD_LEN; k++)
                                begin
                                    res_next[k].value =
                                        request_byte(3'(k), BYTE_FINAL, BYTE_FINAL);
                                end
                                res_next[CMD_LEN] = '{kind: KIND_STATUS, value: 8'h00,
                                                      status: ST_DONE};
                                res_cnt_next = 3'(MAX_RESULTS);
                                phase_next   = PH_IDLE;
                            end
                            else
                            begin
                                do_start_pkg = 1'b1;
                                start_remain = remain_next;
                                start_num    = pkg_num_next;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            CMD_ABORT:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    res_next[0]  = '{kind: KIND_STATUS, value: 8'h00, status: ST_ABORTED};
                    res_cnt_next = 3'd1;
                    phase_next   = PH_IDLE;
                    idx_next     = 3'd0;
                end
            end
            default: ;
        endcase

        if (do_start_pkg)
        begin
            pkg_len_next = start_data + PKG_OVERHEAD;
            pkg_idx_next = 10'd0;
            phase_next   = PH_PACKAGE;
            for (int k = 0; k < CMD_LEN; k++)
            begin
                res_next[k].value = request_byte(3'(k), start_num[7:0], start_num[15:8]);
            end
            res_cnt_next = 3'(CMD_LEN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            res_cnt_reg  <= 3'd0;
            pkg_data_reg <= PKG_DATA_RESET;
            phase_reg    <= PH_IDLE;
            idx_reg      <= 3'd0;
            size_reg     <= 24'd0;
            remain_reg   <= 24'd0;
            pkg_num_reg  <= 16'd0;
            pkg_idx_reg  <= 10'd0;
            pkg_len_reg  <= 10'd0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (cfg_we)
            begin
                pkg_data_reg <= cfg_wdata;
            end
            if (advance)
            begin
                res_cnt_reg  <= res_cnt_next;
                phase_reg    <= phase_next;
                idx_reg      <= idx_next;
                size_reg     <= size_next;
                remain_reg   <= remain_next;
                pkg_num_reg  <= pkg_num_next;
                pkg_idx_reg  <= pkg_idx_next;
                pkg_len_reg  <= pkg_len_next;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                res_cnt_reg <= res_cnt_reg - 3'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            // advance to the next result of the burst
            for (int k = 0; k < MAX_RESULTS - 1; k++)
            begin
                res_reg[k] <= res_reg[k + 1];
            end
        end
    end

endmodule
